FILE: rtl/core/sobel_pkg.sv
package sobel_pkg;

    // Image geometry
    localparam int MAX_WIDTH    = 2048;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 16;
    localparam int WIDTH_CFG_W  = 12;
    localparam int PIX_W        = 8;
    localparam int GRAD_W       = 11;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result slots of one job, in release order
    localparam int SLOT_UP_LEFT   = 0;  // row above, column left of current
    localparam int SLOT_UP_CUR    = 1;  // row above, current column (row end)
    localparam int SLOT_ROW_LEFT  = 2;  // last row, column left of current
    localparam int SLOT_ROW_CUR   = 3;  // last row, current column (image end)
    localparam int NSLOT          = 4;

    // 3x3 window: [row][col], row 0 is the oldest line, col 2 the newest pixel
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        win_t             win;
        logic [NSLOT-1:0] slots;
    } job_t;

    typedef struct packed {
        logic              head_valid;
        logic [QCNT_W-1:0] level;
    } qstat_t;

endpackage

FILE: rtl/core/sobel_ram.sv
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sobel_front.sv
module sobel_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sobel_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  sobel_pkg::qstat_t                  q_stat,
    output logic                               push_valid,
    output sobel_pkg::job_t                    push_job
);
    import sobel_pkg::*;

    // config, held as last column / last row index
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [WIDTH_CFG_W-1:0] cfg_w;

    // raster position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // line store read stage
    logic             st1_valid_reg;
    logic [PIX_W-1:0] st1_pix_reg;
    logic [COL_W-1:0] st1_addr_reg;
    logic             st1_first_col_reg;
    logic             st1_row0_reg;
    logic             st1_left_ok_reg;
    logic             st1_end_row_reg;
    logic             st1_last_row_reg;
    logic             st1_fwd_reg;
    logic [PIX_W-1:0] st1_fwd_above_reg;
    logic [PIX_W-1:0] st1_fwd_two_reg;

    logic             accept;
    logic             end_row;
    logic             last_row;
    logic             fwd_hit;
    logic [PIX_W-1:0] above_rd;
    logic [PIX_W-1:0] two_rd;
    logic [PIX_W-1:0] above_q;
    logic [PIX_W-1:0] two_q;
    logic [PIX_W-1:0] pix_a;
    logic [PIX_W-1:0] pix_b;
    logic [NSLOT-1:0] slots;
    logic [QCNT_W:0]  in_flight;

    win_t win_reg, win_next;

    assign cfg_ready = 1'b1;
    assign cfg_w     = cfg_data[WIDTH_CFG_W-1:0];

    // room in the queue for everything already accepted
    assign in_flight = (QCNT_W+1)'(q_stat.level) + (QCNT_W+1)'(st1_valid_reg);
    assign s_tready  = in_flight < (QCNT_W+1)'(QDEPTH);
    assign accept    = s_tvalid && s_tready;

    assign end_row  = col_reg >= last_col_reg;
    assign last_row = row_reg >= last_row_reg;

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (cfg_w == '0) begin
                        last_col_next = '0;
                    end else if (cfg_w > WIDTH_CFG_W'(MAX_WIDTH)) begin
                        last_col_next = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        last_col_next = COL_W'(cfg_w - WIDTH_CFG_W'(1));
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (cfg_data[ROW_W-1:0] == '0) begin
                        last_row_next = '0;
                    end else begin
                        last_row_next = cfg_data[ROW_W-1:0] - ROW_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (end_row) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // line stores; write back happens in the cycle after the read
    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above_ram (
        .aclk  (aclk),
        .we    (st1_valid_reg),
        .waddr (st1_addr_reg),
        .wdata (st1_pix_reg),
        .raddr (col_reg),
        .rdata (above_rd)
    );

    sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_two_above_ram (
        .aclk  (aclk),
        .we    (st1_valid_reg),
        .waddr (st1_addr_reg),
        .wdata (pix_b),
        .raddr (col_reg),
        .rdata (two_rd)
    );

    // read issued in the same cycle as a write to that entry: take the write data
    assign fwd_hit = st1_valid_reg && (st1_addr_reg == col_reg);

    assign above_q = st1_fwd_reg ? st1_fwd_above_reg : above_rd;
    assign two_q   = st1_fwd_reg ? st1_fwd_two_reg   : two_rd;
    assign pix_a   = st1_row0_reg ? st1_pix_reg : two_q;
    assign pix_b   = st1_row0_reg ? st1_pix_reg : above_q;

    always_comb begin
        win_next = win_reg;
        if (st1_valid_reg) begin
            if (st1_first_col_reg) begin
                for (int i = 0; i < 3; i++) begin
                    win_next[0][i] = pix_a;
                    win_next[1][i] = pix_b;
                    win_next[2][i] = st1_pix_reg;
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    win_next[i][0] = win_reg[i][1];
                    win_next[i][1] = win_reg[i][2];
                end
                win_next[0][2] = pix_a;
                win_next[1][2] = pix_b;
                win_next[2][2] = st1_pix_reg;
            end
        end
    end

    always_comb begin
        slots                = '0;
        slots[SLOT_UP_LEFT]  = !st1_row0_reg && st1_left_ok_reg;
        slots[SLOT_UP_CUR]   = !st1_row0_reg && st1_end_row_reg;
        slots[SLOT_ROW_LEFT] = st1_last_row_reg && st1_left_ok_reg;
        slots[SLOT_ROW_CUR]  = st1_last_row_reg && st1_end_row_reg;
    end

    assign push_valid     = st1_valid_reg && (slots != '0);
    assign push_job.win   = win_next;
    assign push_job.slots = slots;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg  <= COL_W'(RESET_WIDTH - 1);
            last_row_reg  <= ROW_W'(RESET_HEIGHT - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            last_col_reg  <= last_col_next;
            last_row_reg  <= last_row_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            st1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (accept) begin
            st1_pix_reg       <= s_tdata[PIX_W-1:0];
            st1_addr_reg      <= col_reg;
            st1_first_col_reg <= (col_reg == '0);
            st1_row0_reg      <= (row_reg == '0);
            st1_left_ok_reg   <= (col_reg != '0);
            st1_end_row_reg   <= end_row;
            st1_last_row_reg  <= last_row;
            st1_fwd_reg       <= fwd_hit;
            st1_fwd_above_reg <= st1_pix_reg;
            st1_fwd_two_reg   <= pix_b;
        end
    end

endmodule

FILE: rtl/core/sobel_queue.sv
module sobel_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  sobel_pkg::job_t   push_job,
    input  logic              pop,
    output sobel_pkg::job_t   head_job,
    output sobel_pkg::qstat_t q_stat
);
    import sobel_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // front reserves space before it accepts, so a push never sees a full queue
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_valid) - QCNT_W'(pop);
    end

    assign head_job          = mem_reg[rd_ptr_reg];
    assign q_stat.head_valid = (count_reg != '0);
    assign q_stat.level      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/sobel_back.sv
module sobel_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sobel_pkg::qstat_t               q_stat,
    input  sobel_pkg::job_t                 head_job,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sobel_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import sobel_pkg::*;

    // Gx/Gy over rows (rt, rm, 2) and columns (cl, cc, 2) of the window
    function automatic logic [2*GRAD_W-1:0] sobel_grad(win_t w, logic row_sh, logic col_sh);
        logic [1:0]        rt, rm, cl, cc;
        logic signed [11:0] tl, tc, tr, ml, mr, bl, bc, br, gx, gy;
        rt = row_sh ? 2'd1 : 2'd0;
        rm = row_sh ? 2'd2 : 2'd1;
        cl = col_sh ? 2'd1 : 2'd0;
        cc = col_sh ? 2'd2 : 2'd1;
        tl = $signed({4'b0, w[rt][cl]});
        tc = $signed({4'b0, w[rt][cc]});
        tr = $signed({4'b0, w[rt][2]});
        ml = $signed({4'b0, w[rm][cl]});
        mr = $signed({4'b0, w[rm][2]});
        bl = $signed({4'b0, w[2][cl]});
        bc = $signed({4'b0, w[2][cc]});
        br = $signed({4'b0, w[2][2]});
        gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
        gy = (bl + (bc <<< 1) + br) - (tl + (tc <<< 1) + tr);
        return {gy[GRAD_W-1:0], gx[GRAD_W-1:0]};
    endfunction

    logic [NSLOT-1:0]     done_reg, done_next;
    logic [NSLOT-1:0]     pending;
    logic [NSLOT-1:0]     sel;
    logic                 run_end;
    logic                 load;
    logic [2*GRAD_W-1:0]  grads;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    assign pending = head_job.slots & ~done_reg;
    assign sel     = pending & (~pending + NSLOT'(1));
    assign run_end = (pending & ~sel) == '0;
    assign load    = q_stat.head_valid && (!m_tvalid_reg || m_tready);
    assign pop     = load && run_end;

    assign grads = sobel_grad(head_job.win,
                              sel[SLOT_ROW_LEFT] | sel[SLOT_ROW_CUR],
                              sel[SLOT_UP_CUR] | sel[SLOT_ROW_CUR]);

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = run_end ? '0 : (done_reg | sel);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= M_TDATA_W'(grads);
            m_tlast_reg <= run_end;
            m_tuser_reg <= sel[SLOT_ROW_CUR];
        end
    end

endmodule

FILE: rtl/core/sobel_gradient_3x3_replicate.sv
// Channel   Dir  Request content                              Accepted when
// s_        in   tdata[7:0] pixel                             s_tvalid & s_tready
// m_        out  tdata[10:0] grad_x, [21:11] grad_y,          m_tvalid & m_tready
//                [23:22] zero; tlast last_of_run;
//                tuser end_of_image
// cfg_      in   cfg_index 0 image_width, 1 image_height;     cfg_valid & cfg_ready
//                cfg_data value (others ignored)
//
// Cycles: one pixel per clock while s_tready is high. A pixel is read against
// the two line stores in its accept cycle, the window is updated the next cycle
// and a job goes into a 4-deep queue. The result stage emits one result per
// clock while m_tready is high, so a row end (2 results) or last-row pixel
// (up to 4) costs extra cycles; the queue absorbs them and s_tready drops only
// when it fills. A result passes the read stage, queue and output register.
// Reset: aresetn, synchronous, active low; clears counters, queue and the
// output stage; width/height return to 640/480. Line stores are not cleared.
// Stalls: m_tready low holds the output register; the input side keeps
// taking pixels until the queue is full.
module sobel_gradient_3x3_replicate (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pixel requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sobel_pkg::S_TDATA_W-1:0]   s_tdata,    // [7:0] pixel
    // gradient results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sobel_pkg::M_TDATA_W-1:0]   m_tdata,    // [10:0] grad_x, [21:11] grad_y
    output logic                              m_tlast,    // last_of_run
    output logic                              m_tuser,    // [0] end_of_image
    // register writes, only while the block is idle
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sobel_pkg::*;

    logic   push_valid;
    job_t   push_job;
    job_t   head_job;
    logic   pop;
    qstat_t q_stat;

    // front: config, raster counters, line stores, 3x3 window
    sobel_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    // window snapshots plus the mask of results each one releases
    sobel_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .q_stat     (q_stat)
    );

    // back: walks the mask, one Gx/Gy result per clock into the output register unless m_tready stalls it
    sobel_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head_job (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
